// ===== sv/tmtc_pkg.sv =====
`timescale 1ns / 1ps
package tmtc_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    localparam int TIME_W  = 31;
    localparam int TEMPO_W = 24;
    localparam int TPQ_W   = 15;
    localparam int CNT_REG_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int K_W     = 25;                  // ticks_per_quarter * 1000
    localparam int PROD_W  = TIME_W + K_W;        // 56
    localparam int DIVN_W  = PROD_W + 2;          // 2*num + den
    localparam int DIVD_W  = K_W + 1;             // 2*den
    localparam int DIV_STEPS = TIME_W;
    localparam int PC_W    = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    localparam logic [2:0] CMD_LOAD       = 3'd0;
    localparam logic [2:0] CMD_TEMPO_TICK = 3'd1;
    localparam logic [2:0] CMD_TEMPO_MS   = 3'd2;
    localparam logic [2:0] CMD_TICK2MS    = 3'd3;
    localparam logic [2:0] CMD_MS2TICK    = 3'd4;
    localparam logic [2:0] CMD_TLEN2MS    = 3'd5;
    localparam logic [2:0] CMD_MLEN2TICK  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_TPQ    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGCNT = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  tick_lo;
        logic [TIME_W-1:0]  tick_hi;
        logic [TIME_W-1:0]  start_ms;
        logic [TIME_W-1:0]  end_ms;
        logic [TEMPO_W-1:0] tempo;
    } t_seg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLR_IDX,
        OP_STEP,
        OP_PREP,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIN
    } t_op;

    typedef enum logic [1:0] {
        FIN_ZERO,
        FIN_TEMPO,
        FIN_CONV
    } t_fin;

    typedef enum logic [3:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_NOT_QUERY,
        JC_EMPTY,
        JC_HIT,
        JC_MORE,
        JC_TEMPO,
        JC_DIV_MORE
    } t_jc;

    typedef struct packed {
        t_op             op;
        t_fin            fin_sel;
        t_jc             jc;
        logic [PC_W-1:0] target;
        logic            fin;
        logic            in_ready;
    } t_ctl;

    typedef struct packed {
        logic accept;
        logic not_query;
        logic empty;
        logic hit;
        logic more;
        logic tempo_cmd;
        logic div_more;
        logic out_free;
    } t_stat;

    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_DISP  = 4'd1;
    localparam logic [PC_W-1:0] PC_SEED  = 4'd2;
    localparam logic [PC_W-1:0] PC_SCAN  = 4'd3;
    localparam logic [PC_W-1:0] PC_NEXT  = 4'd4;
    localparam logic [PC_W-1:0] PC_MISS  = 4'd5;
    localparam logic [PC_W-1:0] PC_HIT   = 4'd6;
    localparam logic [PC_W-1:0] PC_MUL   = 4'd7;
    localparam logic [PC_W-1:0] PC_DIVI  = 4'd8;
    localparam logic [PC_W-1:0] PC_DIVS  = 4'd9;
    localparam logic [PC_W-1:0] PC_FCONV = 4'd10;
    localparam logic [PC_W-1:0] PC_ZERO  = 4'd11;
    localparam logic [PC_W-1:0] PC_TEMPO = 4'd12;

    function automatic t_ctl mk(t_op op, t_fin fs, t_jc jc, logic [PC_W-1:0] tgt,
                                logic fin, logic rdy);
        t_ctl c;
        c.op       = op;
        c.fin_sel  = fs;
        c.jc       = jc;
        c.target   = tgt;
        c.fin      = fin;
        c.in_ready = rdy;
        return c;
    endfunction

    // control store
    function automatic t_ctl ucode(logic [PC_W-1:0] pc);
        t_ctl c;
        case (pc)
            PC_WAIT:  c = mk(OP_NONE,     FIN_ZERO,  JC_NO_ACCEPT, PC_WAIT,  1'b0, 1'b1);
            PC_DISP:  c = mk(OP_CLR_IDX,  FIN_ZERO,  JC_NOT_QUERY, PC_ZERO,  1'b0, 1'b0);
            PC_SEED:  c = mk(OP_NONE,     FIN_ZERO,  JC_EMPTY,     PC_ZERO,  1'b0, 1'b0);
            PC_SCAN:  c = mk(OP_STEP,     FIN_ZERO,  JC_HIT,       PC_HIT,   1'b0, 1'b0);
            PC_NEXT:  c = mk(OP_NONE,     FIN_ZERO,  JC_MORE,      PC_SCAN,  1'b0, 1'b0);
            PC_MISS:  c = mk(OP_NONE,     FIN_ZERO,  JC_ALWAYS,    PC_ZERO,  1'b0, 1'b0);
            PC_HIT:   c = mk(OP_PREP,     FIN_ZERO,  JC_TEMPO,     PC_TEMPO, 1'b0, 1'b0);
            PC_MUL:   c = mk(OP_MUL,      FIN_ZERO,  JC_NONE,      PC_WAIT,  1'b0, 1'b0);
            PC_DIVI:  c = mk(OP_DIV_INIT, FIN_ZERO,  JC_NONE,      PC_WAIT,  1'b0, 1'b0);
            PC_DIVS:  c = mk(OP_DIV_STEP, FIN_ZERO,  JC_DIV_MORE,  PC_DIVS,  1'b0, 1'b0);
            PC_FCONV: c = mk(OP_FIN,      FIN_CONV,  JC_NONE,      PC_WAIT,  1'b1, 1'b0);
            PC_ZERO:  c = mk(OP_FIN,      FIN_ZERO,  JC_NONE,      PC_WAIT,  1'b1, 1'b0);
            PC_TEMPO: c = mk(OP_FIN,      FIN_TEMPO, JC_NONE,      PC_WAIT,  1'b1, 1'b0);
            default:  c = mk(OP_NONE,     FIN_ZERO,  JC_ALWAYS,    PC_WAIT,  1'b0, 1'b0);
        endcase
        return c;
    endfunction

endpackage

// ===== sv/tmtc_in_if.sv =====
`timescale 1ns / 1ps
interface tmtc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  entry_index;
    logic [30:0] seg_start_tick;
    logic [30:0] seg_end_tick;
    logic [30:0] seg_start_ms;
    logic [30:0] seg_end_ms;
    logic [23:0] seg_tempo_us;
    logic [30:0] query_time;
    logic [30:0] duration;

    modport source (
        output valid, cmd, entry_index, seg_start_tick, seg_end_tick,
               seg_start_ms, seg_end_ms, seg_tempo_us, query_time, duration,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, seg_start_tick, seg_end_tick,
               seg_start_ms, seg_end_ms, seg_tempo_us, query_time, duration,
        output ready
    );
endinterface

// ===== sv/tmtc_out_if.sv =====
`timescale 1ns / 1ps
interface tmtc_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] result_value;
    logic        found;

    modport source (
        output valid, result_value, found,
        input  ready
    );
    modport sink (
        input  valid, result_value, found,
        output ready
    );
endinterface

// ===== sv/tmtc_sequencer.sv =====
`timescale 1ns / 1ps
module tmtc_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmtc_pkg::t_stat i_stat,
    output tmtc_pkg::t_ctl  o_ctl
);
    import tmtc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            ctl;
    logic            take;

    assign ctl   = ucode(r_pc);
    assign o_ctl = ctl;

    always_comb begin
        case (ctl.jc)
            JC_NONE:      take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NO_ACCEPT: take = !i_stat.accept;
            JC_NOT_QUERY: take = i_stat.not_query;
            JC_EMPTY:     take = i_stat.empty;
            JC_HIT:       take = i_stat.hit;
            JC_MORE:      take = i_stat.more;
            JC_TEMPO:     take = i_stat.tempo_cmd;
            JC_DIV_MORE:  take = i_stat.div_more;
            default:      take = 1'b0;
        endcase

        // finishing steps hold until the result register is free
        if (ctl.fin) begin
            n_pc = i_stat.out_free ? PC_WAIT : r_pc;
        end else if (take) begin
            n_pc = ctl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== sv/tmtc_datapath.sv =====
`timescale 1ns / 1ps
module tmtc_datapath #(
    parameter int MAX_SEGMENTS = tmtc_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmtc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tmtc_pkg::TPQ_W-1:0]       i_cfg_data,
    input  tmtc_pkg::t_ctl                   i_ctl,
    output tmtc_pkg::t_stat                  o_stat,
    tmtc_in_if.sink                          i_in,
    tmtc_out_if.source                       o_out
);
    import tmtc_pkg::*;

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    t_seg mem [MAX_SEGMENTS];
    t_seg r_rd;

    logic [TPQ_W-1:0]     r_tpq;
    logic [CNT_REG_W-1:0] r_segcnt;

    logic [2:0]        r_cmd;
    logic [TIME_W-1:0] r_t;
    logic [TIME_W-1:0] r_dur;
    logic [CNT_W-1:0]  r_idx;

    logic [TIME_W-1:0] r_diff;
    logic [K_W-1:0]    r_k;
    logic [PROD_W-1:0] r_num;
    logic [K_W-1:0]    r_den;
    logic [DIVD_W-1:0] r_d2;
    logic [DIVD_W-1:0] r_rem;
    logic [TIME_W-1:0] r_nlow;
    logic [TIME_W-1:0] r_q;
    logic [4:0]        r_cnt;
    logic              r_sat;

    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_value;
    logic              r_out_found;

    logic              accept;
    logic              out_free;
    logic [CNT_W-1:0]  n_eff;
    logic              by_ms;
    logic              to_ms;
    logic [TIME_W-1:0] span_s;
    logic [TIME_W-1:0] span_e;
    logic              hit;
    logic [K_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [DIVN_W-1:0] div_n;
    logic [DIVD_W-1:0] div_d2;
    logic              div_ovf;
    logic [DIVD_W:0]   rem2;
    logic              rem_ge;
    logic [TIME_W-1:0] q_sat;
    logic [TIME_W-1:0] base;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] fin_value;
    logic              fin_found;

    assign accept   = i_in.valid && i_ctl.in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready         = i_ctl.in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.found        = r_out_found;

    always_comb begin
        if (32'(r_segcnt) > MAX_SEGMENTS) begin
            n_eff = CNT_W'(MAX_SEGMENTS);
        end else begin
            n_eff = CNT_W'(r_segcnt);
        end
    end

    assign by_ms  = r_cmd inside {CMD_TEMPO_MS, CMD_MS2TICK, CMD_MLEN2TICK};
    assign to_ms  = r_cmd inside {CMD_TICK2MS, CMD_TLEN2MS};
    assign span_s = by_ms ? r_rd.start_ms : r_rd.tick_lo;
    assign span_e = by_ms ? r_rd.end_ms : r_rd.tick_hi;
    assign hit    = (span_s <= r_t) && (r_t < span_e);

    assign mul_b = to_ms ? K_W'(r_rd.tempo) : r_k;
    assign mul_p = {{(PROD_W-TIME_W){1'b0}}, r_diff} * {{(PROD_W-K_W){1'b0}}, mul_b};

    // round half up: (2*num + den) / (2*den); quotient at or above 2^31 saturates
    assign div_n   = {1'b0, r_num, 1'b0} + DIVN_W'(r_den);
    assign div_d2  = {r_den, 1'b0};
    assign div_ovf = div_n >= DIVN_W'({div_d2, {TIME_W{1'b0}}});

    assign rem2   = {r_rem, r_nlow[TIME_W-1]};
    assign rem_ge = rem2 >= {1'b0, r_d2};

    always_comb begin
        q_sat = r_sat ? TIME_MAX : r_q;
        case (r_cmd)
            CMD_TICK2MS: base = r_rd.start_ms;
            CMD_MS2TICK: base = r_rd.tick_lo;
            default:     base = '0;
        endcase
        sum = {1'b0, base} + {1'b0, q_sat};
        case (i_ctl.fin_sel)
            FIN_TEMPO: begin
                fin_value = TIME_W'(r_rd.tempo);
                fin_found = 1'b1;
            end
            FIN_CONV: begin
                fin_value = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                fin_found = 1'b1;
            end
            default: begin
                fin_value = '0;
                fin_found = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.accept    = accept;
        o_stat.not_query = !(r_cmd inside {[CMD_TEMPO_TICK:CMD_MLEN2TICK]});
        o_stat.empty     = (n_eff == '0);
        o_stat.hit       = hit;
        o_stat.more      = (r_idx < n_eff);
        o_stat.tempo_cmd = r_cmd inside {CMD_TEMPO_TICK, CMD_TEMPO_MS};
        o_stat.div_more  = (r_cnt != 5'(DIV_STEPS - 1));
        o_stat.out_free  = out_free;
    end

    // segment memory: written by a load beat, read at the scan index
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.cmd == CMD_LOAD) && (32'(i_in.entry_index) < MAX_SEGMENTS)) begin
            mem[IDX_W'(i_in.entry_index)] <= '{
                tick_lo:  i_in.seg_start_tick,
                tick_hi:  i_in.seg_end_tick,
                start_ms: i_in.seg_start_ms,
                end_ms:   i_in.seg_end_ms,
                tempo:    i_in.seg_tempo_us
            };
        end
        r_rd <= mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq    <= TPQ_W'(480);
            r_segcnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TPQ:    r_tpq    <= i_cfg_data;
                REG_SEGCNT: r_segcnt <= i_cfg_data[CNT_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.cmd;
            r_t   <= i_in.query_time;
            r_dur <= i_in.duration;
        end
        case (i_ctl.op)
            OP_CLR_IDX: r_idx <= '0;
            OP_STEP: begin
                if (!hit) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            OP_PREP: begin
                case (r_cmd)
                    CMD_TICK2MS: r_diff <= r_t - r_rd.tick_lo;
                    CMD_MS2TICK: r_diff <= r_t - r_rd.start_ms;
                    default:     r_diff <= r_dur;
                endcase
                r_k <= K_W'(r_tpq) * K_W'(MS_PER_SEC);
            end
            OP_MUL: begin
                r_num <= mul_p;
                r_den <= to_ms ? r_k : K_W'(r_rd.tempo);
            end
            OP_DIV_INIT: begin
                r_d2   <= div_d2;
                r_sat  <= div_ovf;
                r_rem  <= DIVD_W'(div_n[DIVN_W-1:TIME_W]);
                r_nlow <= div_n[TIME_W-1:0];
                r_q    <= '0;
                r_cnt  <= '0;
            end
            OP_DIV_STEP: begin
                r_rem  <= rem_ge ? DIVD_W'(rem2 - {1'b0, r_d2}) : rem2[DIVD_W-1:0];
                r_q    <= {r_q[TIME_W-2:0], rem_ge};
                r_nlow <= {r_nlow[TIME_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_FIN && out_free) begin
            r_out_value <= fin_value;
            r_out_found <= fin_found;
        end
    end

endmodule

// ===== sv/tempo_map_time_conversion.sv =====
`timescale 1ns / 1ps
// a load or unknown command goes from dispatch to the zero result, an empty table is
// caught at the seed step; a query scans the slots upward, a tempo command finishes on
// the first hit, a conversion also runs the 31-step radix-2 divider, a miss ends after
// the last live slot; one item at a time, a result may wait while the next beat enters,
// the finishing step holds while the result register is still full
// reset clears the sequencer and the output valid, sets ticks per quarter to 480 and the segment count to 0
module tempo_map_time_conversion #(
    parameter int MAX_SEGMENTS = tmtc_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tmtc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmtc_pkg::TPQ_W-1:0]     i_cfg_data,
    tmtc_in_if.sink                        i_in,
    tmtc_out_if.source                     o_out
);
    import tmtc_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    tmtc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    tmtc_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tmtc_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        t_seg        seg;
        logic [30:0] query_time;
        logic [30:0] duration;
    } t_map_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] value;
        logic              found;
    } t_conv_result;

    class tempo_map_scoreboard;
        t_seg                   slots [MAX_SEGMENTS_DEF];
        logic [TPQ_W-1:0]       tpq;
        logic [CNT_REG_W-1:0]   seg_count;
        t_conv_result           expected_results [$];
        int                     error_count;

        function new();
            foreach (slots[i]) slots[i] = '0;
            tpq = 15'd480;
            seg_count = '0;
            error_count = 0;
        endfunction

        // round half up, saturate to 31 bits; a zero divisor saturates too
        function logic [TIME_W-1:0] scaled_ratio(logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            if (den == 0) return TIME_MAX;
            q = (64'd2 * num + den) / (64'd2 * den);
            return (q > 64'(TIME_MAX)) ? TIME_MAX : q[TIME_W-1:0];
        endfunction

        function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
        endfunction

        function logic [TIME_W-1:0] ms_length(logic [TIME_W-1:0] diff,
                                             logic [TEMPO_W-1:0] tempo);
            return scaled_ratio(64'(diff) * 64'(tempo), 64'(tpq) * 64'(MS_PER_SEC));
        endfunction

        function logic [TIME_W-1:0] tick_length(logic [TIME_W-1:0] diff,
                                               logic [TEMPO_W-1:0] tempo);
            return scaled_ratio(64'(diff) * 64'(tpq) * 64'(MS_PER_SEC), 64'(tempo));
        endfunction

        function t_conv_result convert_command(t_map_cmd c);
            t_conv_result r;
            t_seg s;
            logic [TIME_W-1:0] lo;
            logic [TIME_W-1:0] hi;
            bit by_ms;
            int k;
            int limit;
            r = '0;
            if (c.cmd == CMD_LOAD) begin
                slots[c.slot] = c.seg;
                return r;
            end
            if (c.cmd == CMD_UNUSED) return r;
            by_ms = (c.cmd == CMD_TEMPO_MS || c.cmd == CMD_MS2TICK || c.cmd == CMD_MLEN2TICK);
            limit = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(seg_count);
            // scan downward so the lowest matching slot wins
            k = -1;
            for (int i = limit - 1; i >= 0; i--) begin
                lo = by_ms ? slots[i].start_ms : slots[i].tick_lo;
                hi = by_ms ? slots[i].end_ms : slots[i].tick_hi;
                if (lo <= c.query_time && c.query_time < hi) k = i;
            end
            if (k < 0) return r;
            s = slots[k];
            r.found = 1'b1;
            case (c.cmd)
                CMD_TEMPO_TICK, CMD_TEMPO_MS: r.value = 31'(s.tempo);
                CMD_TICK2MS: begin
                    r.value = sat_add(s.start_ms, ms_length(c.query_time - s.tick_lo, s.tempo));
                end
                CMD_MS2TICK: begin
                    r.value = sat_add(s.tick_lo, tick_length(c.query_time - s.start_ms, s.tempo));
                end
                CMD_TLEN2MS: r.value = ms_length(c.duration, s.tempo);
                default:     r.value = tick_length(c.duration, s.tempo);
            endcase
            return r;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [TPQ_W-1:0] data);
            if (idx == REG_TPQ) tpq = data;
            else seg_count = data[CNT_REG_W-1:0];
        endfunction

        function void note_command(t_map_cmd c);
            expected_results.push_back(convert_command(c));
        endfunction

        function void check_result(logic [TIME_W-1:0] value, logic found);
            t_conv_result exp_r;
            if (expected_results.size() == 0) begin
                $error("unexpected beat: result_value %0d found %0b", value, found);
                error_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (value !== exp_r.value) begin
                $error("result_value: expected %0d, got %0d", exp_r.value, value);
                error_count++;
            end
            if (found !== exp_r.found) begin
                $error("found: expected %0b, got %0b", exp_r.found, found);
                error_count++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TPQ_W-1:0]     i_cfg_data;

    tmtc_in_if  in_if ();
    tmtc_out_if out_if ();

    tempo_map_scoreboard sb;
    t_seg map_copy [MAX_SEGMENTS_DEF];
    int   items_sent = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   steady_sender = 1'b1;
    int   burst_left = 0;

    tempo_map_time_conversion u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #6 i_clk = ~i_clk;

    // receiver: checks results and stalls on a pattern driven by the cycle count
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            sb.check_result(out_if.result_value, out_if.found);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            case (cycle_count[10:9])
                2'd0: out_if.ready <= 1'b1;
                2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_if.ready <= ($urandom_range(0, 2) == 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left <= $urandom_range(5, 25);
                        out_if.ready <= 1'b0;
                    end else begin
                        out_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[tempo_map_time_conversion] ERROR");
        $finish;
    end

    function automatic t_map_cmd random_command();
        t_map_cmd c;
        c.cmd = 3'($urandom);
        c.slot = 4'($urandom);
        c.seg.tick_lo = 31'($urandom);
        c.seg.tick_hi = 31'($urandom);
        c.seg.start_ms = 31'($urandom);
        c.seg.end_ms = 31'($urandom);
        c.seg.tempo = 24'($urandom);
        c.query_time = 31'($urandom);
        c.duration = 31'($urandom);
        return c;
    endfunction

    function automatic t_map_cmd make_load(logic [3:0] slot, logic [30:0] st, logic [30:0] et,
                                           logic [30:0] sm, logic [30:0] em,
                                           logic [23:0] tempo);
        t_map_cmd c;
        c = random_command();
        c.cmd = CMD_LOAD;
        c.slot = slot;
        c.seg.tick_lo = st;
        c.seg.tick_hi = et;
        c.seg.start_ms = sm;
        c.seg.end_ms = em;
        c.seg.tempo = tempo;
        return c;
    endfunction

    function automatic t_map_cmd make_query(logic [2:0] cmd, logic [30:0] qt, logic [30:0] dur);
        t_map_cmd c;
        c = random_command();
        c.cmd = cmd;
        c.query_time = qt;
        c.duration = dur;
        return c;
    endfunction

    function automatic logic [30:0] pick_span();
        if ($urandom_range(0, 19) == 0) return '0;
        return 31'($urandom_range(1, 1 << $urandom_range(4, 26)));
    endfunction

    // mostly inside a live segment, some on its edges, the rest anywhere
    function automatic t_map_cmd random_query(int n_live);
        t_map_cmd c;
        t_seg s;
        logic [30:0] lo;
        logic [30:0] hi;
        bit by_ms;
        int r;
        c = random_command();
        if ($urandom_range(0, 49) == 0) c.cmd = CMD_UNUSED;
        else c.cmd = 3'($urandom_range(CMD_TEMPO_TICK, CMD_MLEN2TICK));
        by_ms = (c.cmd == CMD_TEMPO_MS || c.cmd == CMD_MS2TICK || c.cmd == CMD_MLEN2TICK);
        r = $urandom_range(0, 99);
        if (n_live > 0 && r < 85) begin
            s = map_copy[$urandom_range(0, n_live - 1)];
            lo = by_ms ? s.start_ms : s.tick_lo;
            hi = by_ms ? s.end_ms : s.tick_hi;
            if (r < 70 && hi > lo) c.query_time = lo + 31'($urandom_range(0, hi - lo - 1));
            else if (r % 3 == 0) c.query_time = lo;
            else if (r % 3 == 1) c.query_time = hi - 31'd1;
            else c.query_time = hi;
        end
        case ($urandom_range(0, 9))
            0:       c.duration = '0;
            1:       c.duration = 31'($urandom);
            default: c.duration = 31'($urandom_range(0, 1 << $urandom_range(1, 30)));
        endcase
        return c;
    endfunction

    task automatic send_command(input t_map_cmd c);
        in_if.valid <= 1'b1;
        in_if.cmd <= c.cmd;
        in_if.entry_index <= c.slot;
        in_if.seg_start_tick <= c.seg.tick_lo;
        in_if.seg_end_tick <= c.seg.tick_hi;
        in_if.seg_start_ms <= c.seg.start_ms;
        in_if.seg_end_ms <= c.seg.end_ms;
        in_if.seg_tempo_us <= c.seg.tempo;
        in_if.query_time <= c.query_time;
        in_if.duration <= c.duration;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_command(c);
        if (c.cmd == CMD_LOAD) map_copy[c.slot] = c.seg;
        items_sent++;
    endtask

    task automatic pace_sender();
        if (steady_sender) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
        burst_left = $urandom_range(1, 40);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_config(logic [TPQ_W-1:0] tpq, logic [CNT_REG_W-1:0] count);
        logic [TPQ_W-1:0] count_word;
        drain_results();
        // upper bits of the count word are don't-care
        count_word = {10'($urandom), count};
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_TPQ;
        i_cfg_data <= tpq;
        @(posedge i_clk);
        i_cfg_idx <= REG_SEGCNT;
        i_cfg_data <= count_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.note_register(REG_TPQ, tpq);
        sb.note_register(REG_SEGCNT, count_word);
    endtask

    initial begin
        int stop_at;
        int phase;
        int n_live;
        logic [TPQ_W-1:0] tpq;
        logic [CNT_REG_W-1:0] count;
        logic [30:0] tick_at;
        logic [30:0] ms_at;
        t_map_cmd c;

        sb = new();
        foreach (map_copy[i]) map_copy[i] = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.cmd = '0;
        in_if.entry_index = '0;
        in_if.seg_start_tick = '0;
        in_if.seg_end_tick = '0;
        in_if.seg_start_ms = '0;
        in_if.seg_end_ms = '0;
        in_if.seg_tempo_us = '0;
        in_if.query_time = '0;
        in_if.duration = '0;
        out_if.ready = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset, then an unused opcode
        send_command(make_query(CMD_TEMPO_TICK, 31'd0, 31'd0));
        c = random_command();
        c.cmd = CMD_UNUSED;
        send_command(c);

        // slot 2 has a zero tempo, slot 3 has empty spans at the top
        send_command(make_load(4'd0, 31'd0, 31'd1000, 31'd0, 31'd500, 24'd500000));
        send_command(make_load(4'd1, 31'd1000, TIME_MAX, 31'd500, 31'h4000_0000, '1));
        send_command(make_load(4'd2, 31'd0, 31'd0, 31'h4000_0000, TIME_MAX, '0));
        send_command(make_load(4'd3, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, '1));
        load_config(15'd480, 5'd4);
        send_command(make_query(CMD_TEMPO_TICK, 31'd0, 31'd0));
        send_command(make_query(CMD_TEMPO_TICK, 31'd999, 31'd0));
        send_command(make_query(CMD_TEMPO_TICK, 31'd1000, 31'd0));
        send_command(make_query(CMD_TEMPO_MS, 31'd499, 31'd0));
        send_command(make_query(CMD_TICK2MS, 31'd500, 31'd0));
        send_command(make_query(CMD_MS2TICK, 31'd250, 31'd0));
        send_command(make_query(CMD_TLEN2MS, 31'd0, TIME_MAX));
        send_command(make_query(CMD_MLEN2TICK, 31'h4000_0000, 31'd77));
        send_command(make_query(CMD_MS2TICK, TIME_MAX - 31'd1, 31'd0));
        send_command(make_query(CMD_TICK2MS, TIME_MAX - 31'd1, 31'd0));
        send_command(make_query(CMD_TEMPO_MS, TIME_MAX, 31'd0));
        send_command(make_query(CMD_MLEN2TICK, 31'd0, 31'd0));
        // zero resolution saturates every conversion to ms
        load_config(15'd0, 5'd4);
        send_command(make_query(CMD_TLEN2MS, 31'd5, 31'd5));
        send_command(make_query(CMD_TICK2MS, 31'd5, 31'd0));
        load_config('1, 5'd4);
        send_command(make_query(CMD_MLEN2TICK, 31'd10, TIME_MAX));
        send_command(make_query(CMD_MS2TICK, 31'd100, 31'd0));
        send_command(make_query(CMD_TLEN2MS, 31'd1000, 31'd12345));

        stop_at = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < stop_at) begin
            case (phase)
                0: begin
                    tpq = 15'd480;
                    count = 5'd16;
                end
                1: begin
                    tpq = '1;
                    count = 5'd31;
                end
                2: begin
                    tpq = 15'd1;
                    count = 5'd17;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       tpq = '0;
                        1, 2:    tpq = 15'($urandom_range(1, 20) * 48);
                        default: tpq = 15'($urandom_range(1, 32767));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       count = '0;
                        1:       count = 5'($urandom_range(17, 31));
                        default: count = 5'($urandom_range(1, 16));
                    endcase
                end
            endcase
            load_config(tpq, count);
            steady_sender = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 40);
            n_live = (count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(count);

            // contiguous map over the live slots, now and then a reversed span
            tick_at = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 1 << 20)) : '0;
            ms_at = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 1 << 20)) : '0;
            for (int i = 0; i < n_live; i++) begin
                c = make_load(4'(i), tick_at, tick_at + pick_span(), ms_at, ms_at + pick_span(),
                              24'($urandom_range(250000, 1500000)));
                case ($urandom_range(0, 19))
                    0:       c.seg.tempo = '0;
                    1:       c.seg.tempo = '1;
                    2, 3:    c.seg.tempo = 24'($urandom);
                    default: ;
                endcase
                if (i == n_live - 1 && $urandom_range(0, 7) == 0) begin
                    c.seg.tick_hi = TIME_MAX;
                    c.seg.end_ms = TIME_MAX;
                end
                if ($urandom_range(0, 11) == 0) begin
                    {c.seg.tick_lo, c.seg.tick_hi} = {c.seg.tick_hi, c.seg.tick_lo};
                end
                tick_at = c.seg.tick_hi;
                ms_at = c.seg.end_ms;
                send_command(c);
                pace_sender();
            end

            repeat ($urandom_range(80, 200)) begin
                if ($urandom_range(0, 99) < 5) send_command(random_command());
                else send_command(random_query(n_live));
                pace_sender();
                if ($urandom_range(0, 199) == 0) drain_results();
            end
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
            $display("[tempo_map_time_conversion] OK");
        end else begin
            $display("[tempo_map_time_conversion] ERROR");
        end
        $finish;
    end

endmodule
